// ----- src/e2q_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared types, constants and elaboration-time tables for the Euler angle to
// quaternion pipeline.
// ----------------------------------------------------------------------------
package e2q_pkg;

  // default configuration
  localparam int ANGLE_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // datapath widths
  localparam int SCW = 22;  // sine / cosine word, Q.20 with sign and one guard bit
  localparam int CW  = 34;  // cordic x / y / z word, Q.30
  localparam int QW  = 16;  // quaternion component, Q1.14

  // angle constants in Q.30
  localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
  localparam logic [32:0] PI_Q30      = 33'd3373259426;
  localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;

  // sine and cosine of one half angle
  typedef struct packed {
    logic signed [SCW-1:0] s;
    logic signed [SCW-1:0] c;
  } sincos_t;

  // unsigned shift-subtract quotient, used only for the constant tables
  function automatic logic [63:0] udiv64(input logic [63:0] num,
                                         input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    int          b;
    q   = '0;
    rem = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // arctangent of 2^-i in Q.30 from the alternating series, rounded
  function automatic logic [63:0] atan_q30(input int unsigned i);
    logic [63:0]  pos;
    logic [63:0]  neg;
    logic [63:0]  term;
    int unsigned  k;
    pos = '0;
    neg = '0;
    if (i == 0) begin
      return 64'd843314857;
    end
    for (k = 0; k < 32; k++) begin
      if (i * (2 * k + 1) <= 62) begin
        term = udiv64(64'd1 << (62 - i * (2 * k + 1)), 64'(2 * k + 1));
        if (k[0]) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
    end
    return (pos - neg + (64'd1 << 31)) >> 32;
  endfunction

  // integer square root of a 64-bit word
  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bt;
    int          j;
    n   = n_in;
    res = '0;
    bt  = 64'd1 << 62;
    for (j = 0; j < 32; j++) begin
      if (bt > n) begin
        bt = bt >> 2;
      end
    end
    for (j = 0; j < 32; j++) begin
      if (bt != 0) begin
        if (n >= res + bt) begin
          n   = n - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
    end
    return res;
  endfunction

  // cordic gain compensation in Q.30 for a given stage count
  function automatic logic [63:0] gain_q30(input int unsigned stages);
    logic [63:0] p;
    int unsigned i;
    p = 64'd1 << 62;
    for (i = 0; i < 32; i++) begin
      if (i < stages) begin
        p = p - udiv64(p, (64'd1 << (2 * i)) + 64'd1);
      end
    end
    return (isqrt64(p) + 64'd1) >> 1;
  endfunction

endpackage
`default_nettype wire

// ----- src/e2q_sincos.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_sincos
// Halves one angle, reduces it into [-pi, pi), folds it into [-pi/2, pi/2] and
// runs an unrolled cordic rotation; sine and cosine leave rounded to Q.20.
// Every register advances only on cycles with en high.
// ----------------------------------------------------------------------------
module e2q_sincos #(
  parameter int ANGLE_WIDTH   = e2q_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = e2q_pkg::CORDIC_STAGES_DEF
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [ANGLE_WIDTH-1:0] angle,
  output e2q_pkg::sincos_t       sc
);
  import e2q_pkg::*;

  localparam int M  = (ANGLE_WIDTH > 16) ? ANGLE_WIDTH - 16 : 0;
  localparam int UW = M + 35;
  localparam int N  = CORDIC_STAGES;

  localparam logic [UW-1:0]        OFFSET = UW'(TWO_PI_Q30) << M;
  localparam logic signed [CW-1:0] K_Q30  = CW'(gain_q30(N));
  localparam logic signed [CW-1:0] RND    = CW'(512);
  localparam logic signed [CW-11:0] ONE_HI = (CW-10)'(1048576);

  logic [UW-1:0]         ang_ext;
  logic [UW-1:0]         red_r [M+2];
  logic signed [CW:0]    wr_nxt;
  logic signed [CW:0]    wr_r;
  logic signed [CW:0]    fd_nxt;
  logic                  ng_nxt;
  logic signed [CW-1:0]  cx_r [N+1];
  logic signed [CW-1:0]  cy_r [N+1];
  logic signed [CW-1:0]  cz_r [N+1];
  logic                  ng_r [N+1];
  logic signed [CW-1:0]  cos_pre;
  sincos_t               sc_nxt;
  sincos_t               sc_r;

  // round a Q.30 word to Q.20 and clamp to plus or minus one
  function automatic logic signed [SCW-1:0] to_q20(input logic signed [CW-1:0] v);
    logic signed [CW-1:0]  t;
    logic signed [CW-11:0] r;
    t = v + RND;
    r = t[CW-1:10];
    if (r > ONE_HI) begin
      r = ONE_HI;
    end else if (r < -ONE_HI) begin
      r = -ONE_HI;
    end
    return r[SCW-1:0];
  endfunction

  // half angle in Q.30, lifted by a multiple of 2*pi so it is never negative
  assign ang_ext = {{(UW-ANGLE_WIDTH){angle[ANGLE_WIDTH-1]}}, angle};

  always_ff @(posedge clk) begin
    if (en) begin
      red_r[0] <= (ang_ext << 17) + OFFSET;
    end
  end

  // restoring reduction, one multiple of 2*pi per stage
  for (genvar j = 0; j <= M; j++) begin : g_red
    localparam logic [UW-1:0] SUBV = UW'(TWO_PI_Q30) << (M - j);
    always_ff @(posedge clk) begin
      if (en) begin
        red_r[j+1] <= (red_r[j] >= SUBV) ? red_r[j] - SUBV : red_r[j];
      end
    end
  end

  // wrap [pi, 2*pi) down to [-pi, 0)
  always_comb begin
    wr_nxt = $signed({1'b0, red_r[M+1][CW-1:0]});
    if (red_r[M+1][CW-1:0] >= CW'(PI_Q30)) begin
      wr_nxt = wr_nxt - $signed({2'b00, TWO_PI_Q30});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wr_r <= wr_nxt;
    end
  end

  // fold into [-pi/2, pi/2], cosine sign flips
  always_comb begin
    fd_nxt = wr_r;
    ng_nxt = 1'b0;
    if (wr_r > $signed({2'b00, HALF_PI_Q30})) begin
      fd_nxt = $signed({2'b00, PI_Q30}) - wr_r;
      ng_nxt = 1'b1;
    end else if (wr_r < -$signed({2'b00, HALF_PI_Q30})) begin
      fd_nxt = -$signed({2'b00, PI_Q30}) - wr_r;
      ng_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0] <= K_Q30;
      cy_r[0] <= '0;
      cz_r[0] <= fd_nxt[CW-1:0];
      ng_r[0] <= ng_nxt;
    end
  end

  // cordic rotation stages
  for (genvar i = 0; i < N; i++) begin : g_cordic
    localparam logic signed [CW-1:0] AT = CW'(atan_q30(i));
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cz_r[i][CW-1]) begin
          cx_r[i+1] <= cx_r[i] - (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] + (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] - AT;
        end else begin
          cx_r[i+1] <= cx_r[i] + (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] - (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] + AT;
        end
        ng_r[i+1] <= ng_r[i];
      end
    end
  end

  // apply the fold sign to the cosine, round to Q.20 and clamp
  assign cos_pre  = ng_r[N] ? -cx_r[N] : cx_r[N];
  assign sc_nxt.s = to_q20(cy_r[N]);
  assign sc_nxt.c = to_q20(cos_pre);

  always_ff @(posedge clk) begin
    if (en) begin
      sc_r <= sc_nxt;
    end
  end

  assign sc = sc_r;

endmodule
`default_nettype wire

// ----- src/euler_to_quaternion.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Roll, pitch and yaw in Q4.12 radians to a unit quaternion in Q1.14.
//
//   channel  direction  handshake           word
//   in_      input      in_valid/in_ready   roll, pitch, yaw angles
//   out_     output     out_valid/out_ready quat_w, quat_x, quat_y, quat_z
//
// One word per cycle while the skid entry is empty.
// Reset clears only the valid bits: pipeline, output register and skid entry.
// Output register plus one skid entry: with out_ready low, input keeps flowing
// until a valid word parks in the skid entry, then the whole pipeline holds
// until the skid entry drains.
// ----------------------------------------------------------------------------
module euler_to_quaternion #(
  parameter int ANGLE_WIDTH   = e2q_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = e2q_pkg::CORDIC_STAGES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ANGLE_WIDTH-1:0]          in_roll_angle,
  input  logic [ANGLE_WIDTH-1:0]          in_pitch_angle,
  input  logic [ANGLE_WIDTH-1:0]          in_yaw_angle,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [e2q_pkg::QW-1:0]   out_quat_w,
  output logic signed [e2q_pkg::QW-1:0]   out_quat_x,
  output logic signed [e2q_pkg::QW-1:0]   out_quat_y,
  output logic signed [e2q_pkg::QW-1:0]   out_quat_z
);
  import e2q_pkg::*;

  localparam int M    = (ANGLE_WIDTH > 16) ? ANGLE_WIDTH - 16 : 0;
  localparam int L_SC = M + CORDIC_STAGES + 5;
  localparam int LAT  = L_SC + 5;
  localparam int PW   = 2 * SCW;
  localparam int TW   = 64;
  localparam int VW   = TW - 46;

  // pair product and trig operand slots
  localparam int PR_CC = 0;
  localparam int PR_SS = 1;
  localparam int PR_SC = 2;
  localparam int PR_CS = 3;
  localparam int TV_C  = 0;
  localparam int TV_S  = 1;
  // component slots
  localparam int C_W = 0;
  localparam int C_X = 1;
  localparam int C_Y = 2;
  localparam int C_Z = 3;

  localparam logic signed [TW-1:0] HALF_LSB = TW'(64'd1 << 45);
  localparam logic signed [VW-1:0] QMAX     = VW'(16384);

  logic                  en;
  logic [LAT-1:0]        vld_r;
  sincos_t               sc_roll;
  sincos_t               sc_pitch;
  sincos_t               sc_yaw;
  logic signed [PW-1:0]  pair_r [4];
  logic signed [SCW-1:0] tv_r [2];
  logic signed [PW-1:0]  ph_r [4][2];
  logic signed [PW:0]    pl_r [4][2];
  logic signed [TW-1:0]  trp_r [4][2];
  logic signed [TW-1:0]  sum_r [4];
  logic signed [QW-1:0]  res_r [4];
  logic signed [QW-1:0]  out_q_r [4];
  logic signed [QW-1:0]  skid_q_r [4];
  logic                  out_valid_r;
  logic                  skid_vld_r;

  // round Q.60 to Q.14 and saturate to plus or minus one
  function automatic logic signed [QW-1:0] finish(input logic signed [TW-1:0] s);
    logic signed [TW-1:0] t;
    logic signed [VW-1:0] v;
    t = s + HALF_LSB;
    v = t[TW-1:46];
    if (v > QMAX) begin
      v = QMAX;
    end else if (v < -QMAX) begin
      v = -QMAX;
    end
    return v[QW-1:0];
  endfunction

  // pipeline advances unless the skid entry is occupied
  assign en       = !skid_vld_r;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // half-angle sine and cosine
  e2q_sincos #(
    .ANGLE_WIDTH   (ANGLE_WIDTH),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_roll (
    .clk   (clk),
    .en    (en),
    .angle (in_roll_angle),
    .sc    (sc_roll)
  );

  e2q_sincos #(
    .ANGLE_WIDTH   (ANGLE_WIDTH),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_pitch (
    .clk   (clk),
    .en    (en),
    .angle (in_pitch_angle),
    .sc    (sc_pitch)
  );

  e2q_sincos #(
    .ANGLE_WIDTH   (ANGLE_WIDTH),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_yaw (
    .clk   (clk),
    .en    (en),
    .angle (in_yaw_angle),
    .sc    (sc_yaw)
  );

  // roll by pitch pair products
  always_ff @(posedge clk) begin
    if (en) begin
      pair_r[PR_CC] <= sc_roll.c * sc_pitch.c;
      pair_r[PR_SS] <= sc_roll.s * sc_pitch.s;
      pair_r[PR_SC] <= sc_roll.s * sc_pitch.c;
      pair_r[PR_CS] <= sc_roll.c * sc_pitch.s;
      tv_r[TV_C]    <= sc_yaw.c;
      tv_r[TV_S]    <= sc_yaw.s;
    end
  end

  // yaw products, pair split into high and low halves
  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < 4; p++) begin
        for (int t = 0; t < 2; t++) begin
          ph_r[p][t] <= $signed(pair_r[p][PW-1:SCW]) * tv_r[t];
          pl_r[p][t] <= $signed({1'b0, pair_r[p][SCW-1:0]}) * tv_r[t];
        end
      end
    end
  end

  // merge partial products into Q.60 triple products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < 4; p++) begin
        for (int t = 0; t < 2; t++) begin
          trp_r[p][t] <= ($signed({{(TW-PW){ph_r[p][t][PW-1]}}, ph_r[p][t]}) <<< SCW)
                       + $signed({{(TW-PW-1){pl_r[p][t][PW]}}, pl_r[p][t]});
        end
      end
    end
  end

  // component sums
  always_ff @(posedge clk) begin
    if (en) begin
      sum_r[C_W] <= trp_r[PR_CC][TV_C] + trp_r[PR_SS][TV_S];
      sum_r[C_X] <= trp_r[PR_SC][TV_C] - trp_r[PR_CS][TV_S];
      sum_r[C_Y] <= trp_r[PR_CS][TV_C] + trp_r[PR_SC][TV_S];
      sum_r[C_Z] <= trp_r[PR_CC][TV_S] - trp_r[PR_SS][TV_C];
    end
  end

  // round and saturate
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        res_r[c] <= finish(sum_r[c]);
      end
    end
  end

  // output register and skid entry control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_vld_r  <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_vld_r) begin
        out_valid_r <= 1'b1;
        skid_vld_r  <= 1'b0;
      end else begin
        out_valid_r <= vld_r[LAT-1];
      end
    end else if (vld_r[LAT-1] && !skid_vld_r) begin
      skid_vld_r <= 1'b1;
    end
  end

  // output register and skid entry data
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      if (skid_vld_r) begin
        out_q_r <= skid_q_r;
      end else begin
        out_q_r <= res_r;
      end
    end else if (!skid_vld_r) begin
      skid_q_r <= res_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_quat_w = out_q_r[C_W];
  assign out_quat_x = out_q_r[C_X];
  assign out_quat_y = out_q_r[C_Y];
  assign out_quat_z = out_q_r[C_Z];

endmodule
`default_nettype wire
